// File: hdl/hsac_pkg.sv
// shared types and constants for the hall sensor auto-calibrator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package hsac_pkg;

  // register widths and reset values
  localparam int SETTLE_W  = 17;
  localparam int COLLECT_W = 14;
  localparam logic [SETTLE_W-1:0]  SETTLE_RST  = SETTLE_W'(100000);
  localparam logic [COLLECT_W-1:0] COLLECT_RST = COLLECT_W'(10000);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLLECT = 2'd1;

  // calibration phase codes
  localparam int PH_W = 2;
  localparam logic [PH_W-1:0] PH_SETTLE  = 2'd0;
  localparam logic [PH_W-1:0] PH_COLLECT = 2'd1;
  localparam logic [PH_W-1:0] PH_RUN     = 2'd2;

  // normalized output format
  localparam int OUT_W = 16;
  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: hdl/hsac_fifo.sv
// short register queue between the front (classify) and back (normalize) parts
// depends on hsac_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

module hsac_fifo #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 2
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  wire [WIDTH-1:0]     wr_data,
  input  wire                 pop,
  output logic [WIDTH-1:0]    rd_data,
  output hsac_pkg::q_stat_t   stat
);
  import hsac_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  count_r;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == CNTW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= wr_data;
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNTW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/hsac_front.sv
// front part: accepts ticks, runs settle/collect tracking, fixes calibration
// and queues each tick with its phase; holds the config registers; uses hsac_pkg
`timescale 1ns / 1ps
`default_nettype none

module hsac_front #(
  parameter int ADC_BITS = 12
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire [ADC_BITS-1:0]             in_sample_a,
  input  wire [ADC_BITS-1:0]             in_sample_b,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [hsac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [hsac_pkg::SETTLE_W-1:0]   cfg_data,
  input  hsac_pkg::q_stat_t              q_stat,
  output logic                           q_push,
  output logic [2*ADC_BITS+2:0]          q_entry,
  output logic [ADC_BITS:0]              center_a,
  output logic [ADC_BITS-1:0]            span_a,
  output logic [ADC_BITS:0]              center_b,
  output logic [ADC_BITS-1:0]            span_b
);
  import hsac_pkg::*;

  logic [SETTLE_W-1:0]  settle_r;
  logic [COLLECT_W-1:0] collect_r;

  logic [PH_W-1:0]      phase_r, phase_nxt;
  logic [SETTLE_W-1:0]  tick_r, tick_nxt;
  logic [ADC_BITS-1:0]  max_a_r, max_a_nxt, min_a_r, min_a_nxt;
  logic [ADC_BITS-1:0]  max_b_r, max_b_nxt, min_b_r, min_b_nxt;
  logic                 cal_r, cal_nxt;
  logic [ADC_BITS:0]    center_a_r, center_a_nxt, center_b_r, center_b_nxt;
  logic [ADC_BITS-1:0]  span_a_r, span_a_nxt, span_b_r, span_b_nxt;

  logic [ADC_BITS-1:0]  hi_a, lo_a, hi_b, lo_b;
  logic [SETTLE_W-1:0]  tick_col;
  logic                 acc;

  assign in_ready  = !q_stat.full;
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;
  assign q_push    = acc;
  assign q_entry   = {in_sample_a, in_sample_b, cal_nxt, phase_nxt};

  assign center_a = center_a_r;
  assign span_a   = span_a_r;
  assign center_b = center_b_r;
  assign span_b   = span_b_r;

  // extremes including this tick
  assign hi_a = (in_sample_a > max_a_r) ? in_sample_a : max_a_r;
  assign lo_a = (in_sample_a < min_a_r) ? in_sample_a : min_a_r;
  assign hi_b = (in_sample_b > max_b_r) ? in_sample_b : max_b_r;
  assign lo_b = (in_sample_b < min_b_r) ? in_sample_b : min_b_r;
  assign tick_col = tick_r + SETTLE_W'(in_sample_a != '0);

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    max_a_nxt    = max_a_r;
    min_a_nxt    = min_a_r;
    max_b_nxt    = max_b_r;
    min_b_nxt    = min_b_r;
    cal_nxt      = cal_r;
    center_a_nxt = center_a_r;
    span_a_nxt   = span_a_r;
    center_b_nxt = center_b_r;
    span_b_nxt   = span_b_r;
    if (acc) begin
      unique case (phase_r)
        PH_SETTLE: begin
          if (tick_r < settle_r) begin
            tick_nxt = tick_r + SETTLE_W'(1);
          end else begin
            tick_nxt  = '0;
            phase_nxt = PH_COLLECT;
          end
        end
        PH_COLLECT: begin
          max_a_nxt = hi_a;
          min_a_nxt = lo_a;
          max_b_nxt = hi_b;
          min_b_nxt = lo_b;
          tick_nxt  = tick_col;
          if (tick_col >= SETTLE_W'(collect_r)) begin
            tick_nxt     = '0;
            center_a_nxt = {1'b0, hi_a} + {1'b0, lo_a};
            span_a_nxt   = hi_a - lo_a;
            center_b_nxt = {1'b0, hi_b} + {1'b0, lo_b};
            span_b_nxt   = hi_b - lo_b;
            cal_nxt      = 1'b1;
            phase_nxt    = PH_RUN;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r   <= SETTLE_RST;
      collect_r  <= COLLECT_RST;
      phase_r    <= PH_SETTLE;
      tick_r     <= '0;
      max_a_r    <= '0;
      min_a_r    <= '1;
      max_b_r    <= '0;
      min_b_r    <= '1;
      cal_r      <= 1'b0;
      center_a_r <= '0;
      span_a_r   <= '0;
      center_b_r <= '0;
      span_b_r   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SETTLE:  settle_r  <= cfg_data;
          REG_COLLECT: collect_r <= cfg_data[COLLECT_W-1:0];
          default: begin
          end
        endcase
      end
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      max_a_r    <= max_a_nxt;
      min_a_r    <= min_a_nxt;
      max_b_r    <= max_b_nxt;
      min_b_r    <= min_b_nxt;
      cal_r      <= cal_nxt;
      center_a_r <= center_a_nxt;
      span_a_r   <= span_a_nxt;
      center_b_r <= center_b_nxt;
      span_b_r   <= span_b_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/hsac_div.sv
// one channel normalizer: (2*raw - center) * 2^FRAC_BITS / span, truncated
// toward zero and saturated; restoring divider, one quotient bit a cycle; uses hsac_pkg
`timescale 1ns / 1ps
`default_nettype none

module hsac_div #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 14
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [ADC_BITS-1:0]           raw,
  input  wire [ADC_BITS:0]             center,
  input  wire [ADC_BITS-1:0]           span,
  output logic                         done,
  output logic [hsac_pkg::OUT_W-1:0]   result
);
  import hsac_pkg::*;

  localparam int NUM_W = ADC_BITS + 2;
  localparam int MAG_W = ADC_BITS + 1 + FRAC_BITS;
  localparam int HI_W  = MAG_W - OUT_W;
  localparam int CW    = (HI_W > ADC_BITS) ? HI_W : ADC_BITS;
  localparam int CNT_W = $clog2(OUT_W);

  typedef enum logic [1:0] {D_IDLE, D_PREP, D_ITER, D_DONE} dstate_t;

  dstate_t              state_r;
  logic [NUM_W-1:0]     num_r;
  logic [ADC_BITS-1:0]  den_r;
  logic [ADC_BITS-1:0]  rem_r;
  logic [OUT_W-1:0]     lo_r;
  logic [OUT_W-1:0]     q_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 neg_r;
  logic                 ovf_r;

  logic [NUM_W-1:0]     num_c;
  logic [NUM_W-1:0]     abs_c;
  logic [MAG_W-1:0]     dvd_c;
  logic [CW-1:0]        hi_ext;
  logic [ADC_BITS:0]    trial, diff;
  logic                 ge;
  logic                 sat;

  assign num_c  = {1'b0, raw, 1'b0} - {1'b0, center};
  assign abs_c  = num_r[NUM_W-1] ? (~num_r + NUM_W'(1)) : num_r;
  assign dvd_c  = {abs_c[ADC_BITS:0], {FRAC_BITS{1'b0}}};
  assign hi_ext = CW'(dvd_c[MAG_W-1:OUT_W]);

  assign trial = {rem_r, lo_r[OUT_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  assign done   = (state_r == D_DONE);
  assign sat    = ovf_r || q_r[OUT_W-1];
  assign result = neg_r ? (sat ? SAT_MIN : (~q_r + OUT_W'(1)))
                        : (sat ? SAT_MAX : q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      unique case (state_r) inside
        D_IDLE, D_DONE: begin
          if (start) begin
            num_r   <= num_c;
            den_r   <= (span == '0) ? ADC_BITS'(2) : span;
            state_r <= D_PREP;
          end
        end
        D_PREP: begin
          neg_r   <= num_r[NUM_W-1];
          // quotient at or above 2^OUT_W saturates whatever the sign
          ovf_r   <= (hi_ext >= CW'(den_r));
          rem_r   <= hi_ext[ADC_BITS-1:0];
          lo_r    <= dvd_c[OUT_W-1:0];
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= D_ITER;
        end
        D_ITER: begin
          rem_r <= ge ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
          lo_r  <= {lo_r[OUT_W-2:0], 1'b0};
          q_r   <= {q_r[OUT_W-2:0], ge};
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(OUT_W - 1)) begin
            state_r <= D_DONE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/hsac_back.sv
// back part: pops queued ticks, normalizes calibrated ones on two dividers
// and holds the output register; depends on hsac_pkg and hsac_div
`timescale 1ns / 1ps
`default_nettype none

module hsac_back #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 14
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  hsac_pkg::q_stat_t            q_stat,
  input  wire [2*ADC_BITS+2:0]         q_entry,
  output logic                         q_pop,
  input  wire [ADC_BITS:0]             center_a,
  input  wire [ADC_BITS-1:0]           span_a,
  input  wire [ADC_BITS:0]             center_b,
  input  wire [ADC_BITS-1:0]           span_b,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [hsac_pkg::OUT_W-1:0]   out_norm_a,
  output logic [hsac_pkg::OUT_W-1:0]   out_norm_b,
  output logic                         out_is_calibrated,
  output logic [hsac_pkg::PH_W-1:0]    out_phase_now
);
  import hsac_pkg::*;

  typedef enum logic {B_IDLE, B_DIV} bstate_t;

  bstate_t              state_r;
  logic                 out_valid_r;
  logic [OUT_W-1:0]     norm_a_r, norm_b_r;
  logic                 cal_out_r;
  logic [PH_W-1:0]      phase_out_r, phase_hold_r;

  logic [ADC_BITS-1:0]  e_a, e_b;
  logic                 e_cal;
  logic [PH_W-1:0]      e_phase;
  logic                 out_free;
  logic                 div_start;
  logic                 done_a, done_b;
  logic [OUT_W-1:0]     res_a, res_b;
  logic                 load_out;

  assign e_a     = q_entry[2*ADC_BITS+2 -: ADC_BITS];
  assign e_b     = q_entry[ADC_BITS+2 -: ADC_BITS];
  assign e_cal   = q_entry[PH_W];
  assign e_phase = q_entry[PH_W-1:0];

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == B_IDLE) && !q_stat.empty && out_free;
  assign div_start = q_pop && e_cal;
  // output register takes a new transaction this cycle
  assign load_out  = (q_pop && !e_cal)
                     || ((state_r == B_DIV) && done_a && done_b && out_free);

  assign out_valid         = out_valid_r;
  assign out_norm_a        = norm_a_r;
  assign out_norm_b        = norm_b_r;
  assign out_is_calibrated = cal_out_r;
  assign out_phase_now     = phase_out_r;

  hsac_div #(.ADC_BITS(ADC_BITS), .FRAC_BITS(FRAC_BITS)) u_div_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .raw    (e_a),
    .center (center_a),
    .span   (span_a),
    .done   (done_a),
    .result (res_a)
  );

  hsac_div #(.ADC_BITS(ADC_BITS), .FRAC_BITS(FRAC_BITS)) u_div_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .raw    (e_b),
    .center (center_b),
    .span   (span_b),
    .done   (done_b),
    .result (res_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            if (e_cal) begin
              phase_hold_r <= e_phase;
              state_r      <= B_DIV;
            end else begin
              // not yet calibrated: zero outputs, no division
              norm_a_r    <= '0;
              norm_b_r    <= '0;
              cal_out_r   <= 1'b0;
              phase_out_r <= e_phase;
            end
          end
        end
        B_DIV: begin
          if (done_a && done_b && out_free) begin
            norm_a_r    <= res_a;
            norm_b_r    <= res_b;
            cal_out_r   <= 1'b1;
            phase_out_r <= phase_hold_r;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/hall_sensor_auto_calibrator.sv
// top level of the hall sensor auto-calibrator: front, queue and back parts
// depends on hsac_pkg, hsac_front, hsac_fifo, hsac_back
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  in       | in_valid / in_ready   | in_sample_a, in_sample_b
//  out      | out_valid / out_ready | out_norm_a, out_norm_b, out_is_calibrated,
//           |                       | out_phase_now
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (0 settle, 1 collect)
//
// a tick accepted before calibration is done goes through the queue to the output register, with no division
// a calibrated tick goes through the queue, the 16-step restoring divider of each
// channel (both channels divide side by side) and then the output register
// synchronous active-low reset, no clearing pass
// a two-entry queue lets the front keep accepting while out_ready is low, until the queue is full
`timescale 1ns / 1ps
`default_nettype none

module hall_sensor_auto_calibrator #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 14
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire [ADC_BITS-1:0]             in_sample_a,
  input  wire [ADC_BITS-1:0]             in_sample_b,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [hsac_pkg::OUT_W-1:0] out_norm_a,
  output logic signed [hsac_pkg::OUT_W-1:0] out_norm_b,
  output logic                           out_is_calibrated,
  output logic [hsac_pkg::PH_W-1:0]      out_phase_now,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [hsac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [hsac_pkg::SETTLE_W-1:0]   cfg_data
);
  import hsac_pkg::*;

  localparam int ENT_W   = 2 * ADC_BITS + 3;
  localparam int Q_DEPTH = 2;

  q_stat_t              q_stat;
  logic                 q_push, q_pop;
  logic [ENT_W-1:0]     q_wr, q_rd;
  logic [ADC_BITS:0]    center_a, center_b;
  logic [ADC_BITS-1:0]  span_a, span_b;
  logic [OUT_W-1:0]     norm_a, norm_b;

  assign out_norm_a = $signed(norm_a);
  assign out_norm_b = $signed(norm_b);

  hsac_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample_a (in_sample_a),
    .in_sample_b (in_sample_b),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_entry     (q_wr),
    .center_a    (center_a),
    .span_a      (span_a),
    .center_b    (center_b),
    .span_b      (span_b)
  );

  hsac_fifo #(.WIDTH(ENT_W), .DEPTH(Q_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .stat    (q_stat)
  );

  hsac_back #(.ADC_BITS(ADC_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_entry           (q_rd),
    .q_pop             (q_pop),
    .center_a          (center_a),
    .span_a            (span_a),
    .center_b          (center_b),
    .span_b            (span_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_norm_a        (norm_a),
    .out_norm_b        (norm_b),
    .out_is_calibrated (out_is_calibrated),
    .out_phase_now     (out_phase_now)
  );

endmodule

`default_nettype wire
